[sv/hftd_pkg.sv]
// Shared types and constants for the Huffman tree table decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hftd_pkg;

	localparam int NODE_COUNT_DEF   = 1024;
	localparam int MAX_CODE_LEN_DEF = 16;

	localparam int SYM_W     = 9;
	localparam int CODE_W    = 16;
	localparam int CODE_IW   = $clog2(CODE_W);
	localparam int LEN_W     = 5;
	localparam int BYTE_W    = 8;
	localparam int BYTE_IW   = $clog2(BYTE_W);
	localparam int OUT_SYM_W = 8;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

	localparam logic [S_TUSER_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [S_TUSER_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [S_TUSER_W-1:0] FUNC_DECODE = 2'd2;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_ADD,
		KIND_DECODE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [SYM_W-1:0]   symbol;
		logic [CODE_W-1:0]  code_bits;
		logic [LEN_W-1:0]   code_len;
		logic [BYTE_W-1:0]  data_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_ADD_WALK,
		ENG_ADD_LINK,
		ENG_ADD_CHAIN,
		ENG_DEC_STEP,
		ENG_DEC_FLUSH
	} eng_state_t;

endpackage

`default_nettype wire

[sv/huffman_tree_table_decoder_core.sv]
// Huffman tree table decoder top level: front end, command queue, engine.
// Depends on hftd_pkg, hftd_front, hftd_queue and hftd_engine.
//
// Use: the input stream carries one command per beat, selected by s_tuser:
// clear the tree, add one code (symbol, right-aligned code bits, length),
// or decode one compressed byte walked MSB first. Only decode beats give
// results: one output beat per decoded symbol, end marker or bad code,
// up to eight per byte, with m_tlast on the final one of each byte.
// The front end takes a beat per cycle, unless the queue is full, into a
// two-entry command queue. The engine walks the node table one node read
// per cycle, while results are not stalled, from a single port memory: a
// decode steps bit by bit, then flushes; an add walks, links and chains.
// Each result is held pending until the next result of the byte or the
// end of the byte is known, and only then leaves.
// Reset empties the tree (root kept in flops, no clearing pass) and
// restarts decoding at once. When the receiver stalls, the result register
// and one pending result hold, the engine then holds its walk, and the
// queue fills until s_tready drops.
`default_nettype none

module huffman_tree_table_decoder_core #(
	parameter int NODE_COUNT   = hftd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = hftd_pkg::MAX_CODE_LEN_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// symbol[8:0], code_bits[24:9], code_len[29:25], data_byte[37:30], zero
	input  wire [hftd_pkg::S_TDATA_W-1:0]  s_tdata,
	// func[1:0]
	input  wire [hftd_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// symbol_out[7:0]
	output logic [hftd_pkg::M_TDATA_W-1:0] m_tdata,
	// end_of_data[0], bad_code[1]
	output logic [hftd_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                           m_tlast
);
	import hftd_pkg::*;

	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic qe_valid;
	logic qe_pop;
	cmd_t qe_cmd;

	hftd_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_cmd    (fq_cmd)
	);

	hftd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qe_valid),
		.out_pop   (qe_pop),
		.out_cmd   (qe_cmd)
	);

	hftd_engine #(
		.NODE_COUNT (NODE_COUNT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qe_valid),
		.cmd       (qe_cmd),
		.cmd_pop   (qe_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

[sv/hftd_front.sv]
// Front end: accepts input beats, sorts them into commands and drops
// malformed adds and unused function codes. Depends on hftd_pkg.
`default_nettype none

module hftd_front #(
	parameter int MAX_CODE_LEN = hftd_pkg::MAX_CODE_LEN_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [hftd_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire [hftd_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           q_valid,
	input  wire                            q_ready,
	output hftd_pkg::cmd_t                 q_cmd
);
	import hftd_pkg::*;

	cmd_t cmd_c;
	logic keep_c;
	logic len_ok_c;
	logic valid_s1;
	cmd_t cmd_s1;

	always_comb begin
		cmd_c.symbol    = s_tdata[8:0];
		cmd_c.code_bits = s_tdata[24:9];
		cmd_c.code_len  = s_tdata[29:25];
		cmd_c.data_byte = s_tdata[37:30];
		cmd_c.kind      = KIND_CLEAR;
		len_ok_c = (cmd_c.code_len != '0) &&
			({1'b0, cmd_c.code_len} <= 6'(CODE_W)) &&
			({1'b0, cmd_c.code_len} <= 6'(MAX_CODE_LEN));
		keep_c = 1'b0;
		case (s_tuser)
			FUNC_CLEAR: begin
				cmd_c.kind = KIND_CLEAR;
				keep_c     = 1'b1;
			end
			FUNC_ADD: begin
				cmd_c.kind = KIND_ADD;
				keep_c     = len_ok_c && (cmd_c.symbol <= END_SYMBOL);
			end
			FUNC_DECODE: begin
				cmd_c.kind = KIND_DECODE;
				keep_c     = 1'b1;
			end
			default: begin
				keep_c = 1'b0;
			end
		endcase
	end

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= keep_c;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

`default_nettype wire

[sv/hftd_queue.sv]
// Short command queue between the front end and the tree engine.
// Depends on hftd_pkg for the command type and depth.
`default_nettype none

module hftd_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  hftd_pkg::cmd_t  in_cmd,
	output logic            out_valid,
	input  wire             out_pop,
	output hftd_pkg::cmd_t  out_cmd
);
	import hftd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != CNTW'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

[sv/hftd_engine.sv]
// Back end: node table memory, add and decode sequencer, result register.
// Depends on hftd_pkg for command, state and width definitions.
`default_nettype none

module hftd_engine #(
	parameter int NODE_COUNT = hftd_pkg::NODE_COUNT_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cmd_valid,
	input  hftd_pkg::cmd_t                 cmd,
	output logic                           cmd_pop,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [hftd_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [hftd_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                           m_tlast
);
	import hftd_pkg::*;

	localparam int NW = $clog2(NODE_COUNT);
	localparam int UW = NW + 1;
	localparam int CW = NW + 2;
	localparam int KW = $clog2(BYTE_W + 1);

	typedef struct packed {
		logic                 leaf;
		logic [SYM_W-1:0]     sym;
		logic [1:0]           has;
		logic [1:0][NW-1:0]   kid;
	} node_t;

	typedef struct packed {
		logic [OUT_SYM_W-1:0] sym;
		logic                 eod;
		logic                 bad;
		logic                 last;
	} res_t;

	node_t            mem [NODE_COUNT];
	node_t            mem_q;
	node_t            root_q;
	logic             rd_root_q;
	logic             rd_en;
	logic [NW-1:0]    rd_addr;
	logic             wr_en;
	logic [NW-1:0]    wr_addr;
	node_t            wr_data;
	node_t            nd;

	eng_state_t       state_q, state_d;
	cmd_t             cmd_q;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [KW-1:0]    cnt_q, cnt_d;
	logic [NW-1:0]    cur_q, cur_d;
	logic [NW-1:0]    walk_q, walk_d;
	logic [UW-1:0]    nu_q, nu_d;
	logic             halted_q, halted_d;
	logic             clear_c;
	logic             pv_q, pv_d;
	res_t             pend_q, pend_d;
	logic             mv_q;
	res_t             mout_q;
	logic             push_out;
	res_t             push_res;
	logic             out_free;

	logic [LEN_W-1:0]   pos;
	logic               bit_add;
	logic [LEN_W-1:0]   need;
	logic               no_room;
	logic [UW-1:0]      nu_inc;
	logic [BYTE_IW-1:0] dpos;
	logic               bit_dec;
	logic               gen;
	res_t               gen_res;

	assign nd       = rd_root_q ? root_q : mem_q;
	assign out_free = !mv_q || m_tready;
	assign pos      = cmd_q.code_len - LEN_W'(1) - idx_q;
	assign bit_add  = cmd_q.code_bits[pos[CODE_IW-1:0]];
	assign need     = cmd_q.code_len - idx_q;
	assign no_room  = (CW'(nu_q) + CW'(need)) > CW'(NODE_COUNT);
	assign nu_inc   = nu_q + UW'(1);
	assign dpos     = BYTE_IW'(cnt_q - KW'(1));
	assign bit_dec  = cmd_q.data_byte[dpos];

	assign m_tvalid = mv_q;
	assign m_tdata  = mout_q.sym;
	assign m_tuser  = {mout_q.bad, mout_q.eod};
	assign m_tlast  = mout_q.last;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		cur_d    = cur_q;
		walk_d   = walk_q;
		nu_d     = nu_q;
		halted_d = halted_q;
		pv_d     = pv_q;
		pend_d   = pend_q;
		clear_c  = 1'b0;
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		push_out = 1'b0;
		push_res = pend_q;
		gen      = 1'b0;
		gen_res  = '0;
		case (state_q)
			ENG_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						KIND_CLEAR: begin
							clear_c  = 1'b1;
							nu_d     = UW'(1);
							walk_d   = '0;
							halted_d = 1'b0;
						end
						KIND_ADD: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							cur_d   = '0;
							idx_d   = '0;
							state_d = ENG_ADD_WALK;
						end
						KIND_DECODE: begin
							if (!halted_q) begin
								rd_en   = 1'b1;
								rd_addr = walk_q;
								cnt_d   = KW'(BYTE_W);
								state_d = ENG_DEC_STEP;
							end
						end
						default: begin
							state_d = ENG_IDLE;
						end
					endcase
				end
			end
			ENG_ADD_WALK: begin
				if ((idx_q == cmd_q.code_len - LEN_W'(1)) || !nd.has[bit_add]) begin
					state_d = no_room ? ENG_IDLE : ENG_ADD_LINK;
				end else begin
					rd_en   = 1'b1;
					rd_addr = nd.kid[bit_add];
					cur_d   = nd.kid[bit_add];
					idx_d   = idx_q + LEN_W'(1);
				end
			end
			ENG_ADD_LINK: begin
				wr_en                 = 1'b1;
				wr_addr               = cur_q;
				wr_data               = nd;
				wr_data.has[bit_add]  = 1'b1;
				wr_data.kid[bit_add]  = nu_q[NW-1:0];
				idx_d                 = idx_q + LEN_W'(1);
				state_d               = ENG_ADD_CHAIN;
			end
			ENG_ADD_CHAIN: begin
				wr_en   = 1'b1;
				wr_addr = nu_q[NW-1:0];
				nu_d    = nu_inc;
				if (idx_q == cmd_q.code_len) begin
					wr_data.leaf = 1'b1;
					wr_data.sym  = cmd_q.symbol;
					state_d      = ENG_IDLE;
				end else begin
					wr_data.has[bit_add] = 1'b1;
					wr_data.kid[bit_add] = nu_inc[NW-1:0];
					idx_d                = idx_q + LEN_W'(1);
				end
			end
			ENG_DEC_STEP: begin
				if (!pv_q || out_free) begin
					if (nd.leaf) begin
						gen = 1'b1;
						if (nd.sym == END_SYMBOL) begin
							gen_res.eod = 1'b1;
							halted_d    = 1'b1;
							state_d     = ENG_DEC_FLUSH;
						end else begin
							gen_res.sym = nd.sym[OUT_SYM_W-1:0];
							walk_d      = '0;
							rd_en       = 1'b1;
							rd_addr     = '0;
						end
					end else if (cnt_q == '0) begin
						state_d = ENG_DEC_FLUSH;
					end else if (!nd.has[bit_dec]) begin
						gen         = 1'b1;
						gen_res.bad = 1'b1;
						halted_d    = 1'b1;
						state_d     = ENG_DEC_FLUSH;
					end else begin
						rd_en   = 1'b1;
						rd_addr = nd.kid[bit_dec];
						walk_d  = nd.kid[bit_dec];
						cnt_d   = cnt_q - KW'(1);
					end
				end
				if (gen) begin
					push_out = pv_q;
					pend_d   = gen_res;
					pv_d     = 1'b1;
				end
			end
			ENG_DEC_FLUSH: begin
				if (!pv_q) begin
					state_d = ENG_IDLE;
				end else if (out_free) begin
					push_out      = 1'b1;
					push_res.last = 1'b1;
					pv_d          = 1'b0;
					state_d       = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ENG_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			cur_q     <= '0;
			walk_q    <= '0;
			nu_q      <= UW'(1);
			halted_q  <= 1'b0;
			pv_q      <= 1'b0;
			mv_q      <= 1'b0;
			rd_root_q <= 1'b1;
			root_q    <= '0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			cnt_q    <= cnt_d;
			cur_q    <= cur_d;
			walk_q   <= walk_d;
			nu_q     <= nu_d;
			halted_q <= halted_d;
			pv_q     <= pv_d;
			if (rd_en) begin
				rd_root_q <= (rd_addr == '0);
			end
			if (clear_c) begin
				root_q <= '0;
			end else if (wr_en && wr_addr == '0) begin
				root_q <= wr_data;
			end
			if (push_out) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		pend_q <= pend_d;
		if (push_out) begin
			mout_q <= push_res;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_addr != '0) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_huffman_tree_table_decoder_core.sv]
// Testbench for huffman_tree_table_decoder_core: builds code trees, decodes bytes
// and checks every result beat against an in-bench tree walker.
// Depends on hftd_pkg and the core RTL only.
`default_nettype none

module tb_huffman_tree_table_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import hftd_pkg::*;

	localparam int TREE_NODES = NODE_COUNT_DEF;
	localparam int MAX_LEN = MAX_CODE_LEN_DEF;
	localparam int KID_W = $clog2(TREE_NODES);
	localparam int RANDOM_ITEMS = 320;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [S_TUSER_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] sym;
		logic       eod;
		logic       bad;
		logic       last;
	} dec_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;

	huffman_tree_table_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	logic             node_leaf [TREE_NODES];
	logic [8:0]       node_sym  [TREE_NODES];
	logic [1:0]       node_has  [TREE_NODES];
	logic [KID_W-1:0] node_kid  [TREE_NODES][2];
	int unsigned      nodes_alloc;
	logic [KID_W-1:0] walk_at;
	bit               walk_halted;

	dec_result_t expected_results[$];

	int mismatches;
	int items_sent;
	int adds_sent;
	int adds_dropped;
	int decodes_sent;
	int clears_sent;
	int results_seen;
	int symbols_seen;
	int ends_seen;
	int bads_seen;
	int cycle_count;
	bit back_to_back;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("huffman_tree_table_decoder_core test failed");
			$finish;
		end
	end

	function automatic void tree_clear();
		node_leaf[0] = 1'b0;
		node_sym[0] = '0;
		node_has[0] = 2'b00;
		node_kid[0][0] = '0;
		node_kid[0][1] = '0;
		nodes_alloc = 1;
		walk_at = '0;
		walk_halted = 1'b0;
	endfunction

	function automatic void tree_init_node(int unsigned n, logic leaf, logic [8:0] sym);
		node_leaf[n] = leaf;
		node_sym[n] = sym;
		node_has[n] = 2'b00;
		node_kid[n][0] = '0;
		node_kid[n][1] = '0;
	endfunction

	function automatic bit tree_add(logic [8:0] sym, logic [15:0] bits, logic [4:0] len);
		int unsigned at;
		int unsigned need;
		int unsigned n;
		int i;
		bit b;
		bit gap_found;
		if (len == 0 || len > CODE_W || len > MAX_LEN || sym > END_SYMBOL)
			return 1'b0;
		at = 0;
		need = 1;
		gap_found = 1'b0;
		for (i = 0; i + 1 < len; i++) begin
			b = bits[len - 1 - i];
			if (gap_found)
				need++;
			else if (node_has[at][b])
				at = int'(node_kid[at][b]);
			else begin
				gap_found = 1'b1;
				need++;
			end
		end
		if (nodes_alloc + need > TREE_NODES)
			return 1'b0;
		at = 0;
		for (i = 0; i + 1 < len; i++) begin
			b = bits[len - 1 - i];
			if (!node_has[at][b]) begin
				n = nodes_alloc++;
				tree_init_node(n, 1'b0, '0);
				node_has[at][b] = 1'b1;
				node_kid[at][b] = KID_W'(n);
			end
			at = int'(node_kid[at][b]);
		end
		b = bits[0];
		n = nodes_alloc++;
		tree_init_node(n, 1'b1, sym);
		node_has[at][b] = 1'b1;
		node_kid[at][b] = KID_W'(n);
		return 1'b1;
	endfunction

	function automatic void decode_byte(logic [7:0] data);
		dec_result_t found[$];
		dec_result_t r;
		int k;
		bit b;
		bit stop;
		stop = 1'b0;
		for (k = 7; k >= 0 && !stop; k--) begin
			b = data[k];
			r = '0;
			if (!node_has[walk_at][b]) begin
				r.bad = 1'b1;
				found.push_back(r);
				walk_halted = 1'b1;
				stop = 1'b1;
			end else begin
				walk_at = node_kid[walk_at][b];
				if (node_leaf[walk_at]) begin
					if (node_sym[walk_at] == END_SYMBOL) begin
						r.eod = 1'b1;
						found.push_back(r);
						walk_halted = 1'b1;
						stop = 1'b1;
					end else begin
						r.sym = node_sym[walk_at][7:0];
						found.push_back(r);
						walk_at = '0;
					end
				end
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			expected_results.push_back(found[i]);
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("MISMATCH %s: expected 0x%0h got 0x%0h (result %0d, cycle %0d)", what, want,
			got, results_seen, cycle_count);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0)
				report_mismatch("unexpected beat", 0, {m_tdata, m_tuser, m_tlast});
			else begin
				want = expected_results.pop_front();
				if (want.eod)
					ends_seen++;
				else if (want.bad)
					bads_seen++;
				else
					symbols_seen++;
				if (m_tdata !== want.sym)
					report_mismatch("symbol_out", want.sym, m_tdata);
				if (m_tuser[0] !== want.eod)
					report_mismatch("end_of_data", want.eod, m_tuser[0]);
				if (m_tuser[1] !== want.bad)
					report_mismatch("bad_code", want.bad, m_tuser[1]);
				if (m_tlast !== want.last)
					report_mismatch("last", want.last, m_tlast);
			end
		end
	end

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = back_to_back ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_item(logic [1:0] func, logic [8:0] sym, logic [15:0] code,
			logic [4:0] len, logic [7:0] data);
		int gap;
		gap = back_to_back ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {2'b00, data, len, code, sym};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		case (func)
			FUNC_CLEAR: begin
				tree_clear();
				clears_sent++;
			end
			FUNC_ADD: begin
				adds_sent++;
				if (!tree_add(sym, code, len))
					adds_dropped++;
			end
			FUNC_DECODE: begin
				if (!walk_halted) begin
					decodes_sent++;
					decode_byte(data);
				end
			end
			default: ;
		endcase
	endtask

	task automatic do_clear();
		send_item(FUNC_CLEAR, 9'($urandom), 16'($urandom), 5'($urandom), 8'($urandom));
	endtask

	task automatic do_add(logic [8:0] sym, logic [15:0] code, logic [4:0] len);
		send_item(FUNC_ADD, sym, code, len, 8'($urandom));
	endtask

	task automatic do_decode(logic [7:0] data);
		send_item(FUNC_DECODE, 9'($urandom), 16'($urandom), 5'($urandom), data);
	endtask

	task automatic send_noise();
		logic [1:0] func;
		func = ($urandom_range(0, 15) == 0) ? FUNC_CLEAR : 2'($urandom_range(1, 3));
		send_item(func, 9'($urandom), 16'($urandom), 5'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		if (expected_results.size() != 0) begin
			s_tvalid <= 1'b0;
			while (expected_results.size() != 0) @(posedge clk);
		end
	endtask

	task automatic test_empty_tree();
		do_decode(8'h00);
		do_decode(8'hFF);
		do_clear();
	endtask

	task automatic test_short_codes();
		do_add(9'd255, 16'b00, 5'd2);
		do_add(9'd0, 16'b01, 5'd2);
		do_add(9'd128, 16'b100, 5'd3);
		do_add(END_SYMBOL, 16'b101, 5'd3);
		do_add(9'd48, 16'b110, 5'd3);
		do_add(9'd129, 16'b111, 5'd3);
		do_add(9'h012, 16'hFFFF, 5'd31);
		do_add(9'h034, 16'h0000, 5'd17);
		do_add(9'h056, 16'h0000, 5'd0);
		do_add(9'h1FF, 16'b00, 5'd2);
		send_item(FUNC_UNUSED, 9'h033, 16'b00, 5'd2, 8'h00);
		do_decode(8'h19);
		do_decode(8'hB8);
		wait_drained();
		do_decode(8'h00);
		do_decode(8'hD0);
		do_decode(8'hFF);
		do_clear();
	endtask

	task automatic test_long_codes();
		do_add(9'h041, 16'hFFFF, 5'd16);
		do_add(9'h042, 16'h0000, 5'd16);
		do_decode(8'hFF);
		do_decode(8'hFF);
		do_decode(8'h00);
		do_decode(8'h00);
		do_decode(8'h80);
		do_clear();
	endtask

	// Dry-run the add on the predictor's view of free space, without changing it.
	function automatic bit tree_add_fits(logic [15:0] code);
		int unsigned at;
		int unsigned need;
		int i;
		bit gap_found;
		at = 0;
		need = 1;
		gap_found = 1'b0;
		for (i = 0; i < CODE_W - 1; i++) begin
			if (gap_found || !node_has[at][code[CODE_W - 1 - i]]) begin
				gap_found = 1'b1;
				need++;
			end else
				at = int'(node_kid[at][code[CODE_W - 1 - i]]);
		end
		return nodes_alloc + need <= TREE_NODES;
	endfunction

	task automatic test_table_full();
		logic [15:0] code;
		logic [15:0] kept_code;
		int tries;
		int dropped_before;
		kept_code = '0;
		tries = 0;
		dropped_before = adds_dropped;
		while (adds_dropped - dropped_before < 4 && tries < 160) begin
			code = 16'($urandom);
			if (tree_add_fits(code))
				kept_code = code;
			do_add(9'($urandom_range(0, 255)), code, 5'd16);
			tries++;
		end
		do_decode(kept_code[15:8]);
		do_decode(kept_code[7:0]);
		wait_drained();
		do_clear();
	endtask

	task automatic test_random_sequences(int target);
		int unsigned cbits [32];
		int          clen  [32];
		int cnt;
		int leaves;
		int maxlen;
		int end_slot;
		int tries;
		int i;
		int j;
		int n_dec;
		while (items_sent < target) begin
			back_to_back = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 7) != 0)
				do_clear();
			maxlen = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(2, 6);
			leaves = $urandom_range(2, 24);
			cbits[0] = 0;
			clen[0] = 0;
			cnt = 1;
			tries = 0;
			while (cnt < leaves && tries < 200) begin
				i = $urandom_range(0, cnt - 1);
				if (clen[i] < maxlen) begin
					cbits[cnt] = (cbits[i] << 1) | 1;
					clen[cnt] = clen[i] + 1;
					cbits[i] = cbits[i] << 1;
					clen[i]++;
					cnt++;
				end
				tries++;
			end
			end_slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cnt - 1) : -1;
			for (j = 0; j < cnt; j++)
				do_add((j == end_slot) ? END_SYMBOL : 9'($urandom_range(0, 255)),
					16'(cbits[j] | ($urandom << clen[j])), 5'(clen[j]));
			if ($urandom_range(0, 3) == 0)
				send_noise();
			n_dec = $urandom_range(3, 12);
			for (j = 0; j < n_dec; j++) begin
				do_decode(8'($urandom));
				if ($urandom_range(0, 9) == 0)
					send_noise();
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		back_to_back = 1'b0;
		tree_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tree();
		test_short_codes();
		test_long_codes();
		test_table_full();
		test_random_sequences(RANDOM_ITEMS);

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d items: %0d clears, %0d adds (%0d dropped), %0d decodes",
			items_sent, clears_sent, adds_sent, adds_dropped, decodes_sent);
		$display("checked %0d result beats: %0d symbols, %0d end markers, %0d bad codes",
			results_seen, symbols_seen, ends_seen, bads_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("huffman_tree_table_decoder_core test passed");
		else
			$display("huffman_tree_table_decoder_core test failed");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
sv/hftd_pkg.sv
sv/hftd_front.sv
sv/hftd_queue.sv
sv/hftd_engine.sv
sv/huffman_tree_table_decoder_core.sv
tb/sv/tb_huffman_tree_table_decoder_core.sv
